/* design/sbsph_pkg.sv */
// Shared types, constants and helpers of the spectrum band smoothing block.
`default_nettype none

package sbsph_pkg;

   localparam int BAND_W    = 8;
   localparam int LEVEL_W   = 16;
   localparam int TIME_W    = 32;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_W     = 16;
   localparam int REQ_W     = 56;
   localparam int RSP_W     = 40;

   localparam int BAND_COUNT_DEF = 256;

   localparam logic [2:0]         RESET_RESOLUTION = 3'd1;
   localparam logic [15:0]        RESET_HOLD_TIME  = 16'd2000;
   localparam logic signed [15:0] RESET_FLOOR      = 16'sd0;
   localparam logic signed [15:0] RESET_CEILING    = 16'sd30720;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_RESOLUTION = 3'd0,
      REG_OFFSET     = 3'd1,
      REG_TILT       = 3'd2,
      REG_ALPHA      = 3'd3,
      REG_HOLD_EN    = 3'd4,
      REG_HOLD_TIME  = 3'd5,
      REG_FLOOR      = 3'd6,
      REG_CEILING    = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [2:0]         res_sel;
      logic signed [15:0] offset;
      logic               tilt_en;
      logic [15:0]        alpha;
      logic               hold_en;
      logic [15:0]        hold_time;
      logic signed [15:0] lvl_floor;
      logic signed [15:0] lvl_ceil;
   } cfg_type;

   // One store entry: timestamp of the held peak, held peak, smoothed level.
   typedef struct packed {
      logic [TIME_W-1:0]         stamp;
      logic signed [LEVEL_W-1:0] peak;
      logic signed [LEVEL_W-1:0] smooth;
   } entry_type;

   // Tilt per band in Q8.8: 3 dB (768) divided by the bands per octave.
   // The quotient is exact for every resolution, so no rounding is left.
   // Selectors above four saturate to 24 bands per octave.
   function automatic logic [9:0] tilt_weight(input logic [2:0] sel);
      logic [9:0] w;
      begin
         case (sel)
            3'd0:    w = 10'd768;
            3'd1:    w = 10'd256;
            3'd2:    w = 10'd128;
            3'd3:    w = 10'd64;
            default: w = 10'd32;
         endcase
         return w;
      end
   endfunction

endpackage

`default_nettype wire

/* design/sbsph_csr.sv */
// Configuration registers and the store clear request.
`default_nettype none

module sbsph_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [sbsph_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [sbsph_pkg::CSR_W-1:0]         csr_wdata,
   output sbsph_pkg::cfg_type                       cfg,
   output logic                                     store_clear
);

   logic [2:0]         res_ff;
   logic signed [15:0] offset_ff;
   logic               tilt_ff;
   logic [15:0]        alpha_ff;
   logic               hold_en_ff;
   logic [15:0]        hold_time_ff;
   logic signed [15:0] floor_ff;
   logic signed [15:0] ceil_ff;

   sbsph_pkg::reg_index_type idx;

   assign idx = sbsph_pkg::reg_index_type'(csr_index);

   // Every write of the resolution register wipes the stores, even if unchanged.
   assign store_clear = csr_we && (idx == sbsph_pkg::REG_RESOLUTION);

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff       <= sbsph_pkg::RESET_RESOLUTION;
         offset_ff    <= '0;
         tilt_ff      <= 1'b0;
         alpha_ff     <= '0;
         hold_en_ff   <= 1'b0;
         hold_time_ff <= sbsph_pkg::RESET_HOLD_TIME;
         floor_ff     <= sbsph_pkg::RESET_FLOOR;
         ceil_ff      <= sbsph_pkg::RESET_CEILING;
      end else if (csr_we) begin
         case (idx)
            sbsph_pkg::REG_RESOLUTION: res_ff       <= csr_wdata[2:0];
            sbsph_pkg::REG_OFFSET:     offset_ff    <= $signed(csr_wdata);
            sbsph_pkg::REG_TILT:       tilt_ff      <= csr_wdata[0];
            sbsph_pkg::REG_ALPHA:      alpha_ff     <= csr_wdata;
            sbsph_pkg::REG_HOLD_EN:    hold_en_ff   <= csr_wdata[0];
            sbsph_pkg::REG_HOLD_TIME:  hold_time_ff <= csr_wdata;
            sbsph_pkg::REG_FLOOR:      floor_ff     <= $signed(csr_wdata);
            sbsph_pkg::REG_CEILING:    ceil_ff      <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.res_sel   = res_ff;
      cfg.offset    = offset_ff;
      cfg.tilt_en   = tilt_ff;
      cfg.alpha     = alpha_ff;
      cfg.hold_en   = hold_en_ff;
      cfg.hold_time = hold_time_ff;
      cfg.lvl_floor = floor_ff;
      cfg.lvl_ceil  = ceil_ff;
   end

endmodule

`default_nettype wire

/* design/sbsph_store.sv */
// Per-band state memory with registered read and per-entry valid bits.
`default_nettype none

module sbsph_store #(
   parameter int DEPTH = sbsph_pkg::BAND_COUNT_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          store_clear,
   input  wire logic signed [15:0]            clear_level,
   input  wire logic                          rd_en,
   input  wire logic [AW-1:0]                 rd_addr,
   output sbsph_pkg::entry_type               rd_entry,
   input  wire logic                          wr_en,
   input  wire logic [AW-1:0]                 wr_addr,
   input  wire sbsph_pkg::entry_type          wr_entry
);

   sbsph_pkg::entry_type store_mem_ff [DEPTH];
   sbsph_pkg::entry_type mem_rd_ff;
   logic [DEPTH-1:0]     vld_ff;
   logic                 vld_rd_ff;
   logic signed [15:0]   clr_level_ff;
   sbsph_pkg::entry_type blank;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem_ff[wr_addr] <= wr_entry;
      end
      if (rd_en) begin
         mem_rd_ff <= store_mem_ff[rd_addr];
      end
   end

   // An entry not written since the last clear reads as the floor captured then.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         vld_rd_ff    <= 1'b0;
         clr_level_ff <= sbsph_pkg::RESET_FLOOR;
      end else if (store_clear) begin
         vld_ff       <= '0;
         vld_rd_ff    <= 1'b0;
         clr_level_ff <= clear_level;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            vld_rd_ff <= vld_ff[rd_addr];
         end
      end
   end

   always_comb begin
      blank.stamp  = '0;
      blank.peak   = clr_level_ff;
      blank.smooth = clr_level_ff;
      rd_entry     = vld_rd_ff ? mem_rd_ff : blank;
   end

endmodule

`default_nettype wire

/* design/sbsph_pipe.sv */
// Three-stage level, smoothing and peak-hold pipeline with output register.
`default_nettype none

module sbsph_pipe #(
   parameter int BAND_COUNT = sbsph_pkg::BAND_COUNT_DEF,
   parameter int AW         = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire sbsph_pkg::cfg_type            cfg,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [sbsph_pkg::REQ_W-1:0]   req_tdata,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [sbsph_pkg::RSP_W-1:0]        rsp_tdata,
   output logic                               rd_en,
   output logic [AW-1:0]                      rd_addr,
   input  wire sbsph_pkg::entry_type          rd_entry,
   output logic                               wr_en,
   output logic [AW-1:0]                      wr_addr,
   output sbsph_pkg::entry_type               wr_entry
);

   // Input fields.
   logic [7:0]         band_in;
   logic signed [15:0] raw_in;
   logic [31:0]        now_in;
   logic               inr_in;
   logic               hazard;
   logic               accept;

   // Stage registers.
   logic               p1_vld_ff, p1_vld_in, p1_inr_ff;
   logic [7:0]         p1_band_ff;
   logic signed [15:0] p1_raw_ff;
   logic [31:0]        p1_now_ff;

   logic               p2_vld_ff, p2_vld_in, p2_inr_ff;
   logic [7:0]         p2_band_ff;
   logic [31:0]        p2_now_ff;
   logic signed [15:0] p2_x_ff, p2_x_in;
   sbsph_pkg::entry_type p2_ent_ff;

   logic               p3_vld_ff, p3_vld_in, p3_inr_ff;
   logic [7:0]         p3_band_ff;
   logic [31:0]        p3_now_ff;
   logic signed [15:0] p3_x_ff;
   logic signed [17:0] p3_step_ff, p3_step_in;
   logic signed [15:0] p3_peak_ff;
   logic [31:0]        p3_stamp_ff;
   logic               p3_exp_ff, p3_exp_in;

   logic               out_vld_ff, out_vld_in;
   logic [7:0]         out_band_ff;
   logic signed [15:0] out_smooth_ff, out_smooth_in;
   logic signed [15:0] out_peak_ff, out_peak_in;

   logic mv1, mv2, mv3, rdy1, rdy2, rdy3;

   // Stage 1 arithmetic.
   logic [17:0]        tilt;
   logic signed [19:0] x_sum, x_lo, floor20, ceil20;

   // Stage 2 arithmetic.
   logic signed [16:0] diff;
   logic signed [33:0] prod;
   logic [31:0]        age;

   // Stage 3 arithmetic.
   logic signed [17:0] s_wide;
   logic signed [15:0] s_new, peak_new;
   logic [31:0]        stamp_new;
   logic               take;

   assign band_in = req_tdata[7:0];
   assign raw_in  = $signed(req_tdata[23:8]);
   assign now_in  = req_tdata[55:24];
   assign inr_in  = (32'(band_in) < 32'(BAND_COUNT));

   // A band still in flight must land in the store before it is read again.
   assign hazard = inr_in && ((p1_vld_ff && p1_inr_ff && (p1_band_ff == band_in)) ||
                              (p2_vld_ff && p2_inr_ff && (p2_band_ff == band_in)) ||
                              (p3_vld_ff && p3_inr_ff && (p3_band_ff == band_in)));

   assign mv3  = p3_vld_ff && (!out_vld_ff || rsp_tready);
   assign rdy3 = !p3_vld_ff || mv3;
   assign mv2  = p2_vld_ff && rdy3;
   assign rdy2 = !p2_vld_ff || mv2;
   assign mv1  = p1_vld_ff && rdy2;
   assign rdy1 = !p1_vld_ff || mv1;

   assign req_tready = rdy1 && !hazard;
   assign accept     = req_tvalid && req_tready;

   assign rd_en   = accept && inr_in;
   assign rd_addr = band_in[AW-1:0];

   // Stage 1: offset, tilt and clamp.
   always_comb begin
      tilt    = cfg.tilt_en ? (18'(p1_band_ff) * 18'(sbsph_pkg::tilt_weight(cfg.res_sel)))
                            : 18'd0;
      x_sum   = $signed({{4{p1_raw_ff[15]}}, p1_raw_ff})
              + $signed({{4{cfg.offset[15]}}, cfg.offset})
              + $signed({2'b00, tilt});
      floor20 = $signed({{4{cfg.lvl_floor[15]}}, cfg.lvl_floor});
      ceil20  = $signed({{4{cfg.lvl_ceil[15]}}, cfg.lvl_ceil});
      x_lo    = (x_sum < floor20) ? floor20 : x_sum;
      p2_x_in = (x_lo > ceil20) ? cfg.lvl_ceil : x_lo[15:0];
   end

   // Stage 2: s' = x + floor(alpha * (s - x) / 65536), the same as the weighted mean.
   always_comb begin
      diff       = $signed({p2_ent_ff.smooth[15], p2_ent_ff.smooth})
                 - $signed({p2_x_ff[15], p2_x_ff});
      prod       = diff * $signed({1'b0, cfg.alpha});
      p3_step_in = prod[33:16];
      age        = p2_now_ff - p2_ent_ff.stamp;
      p3_exp_in  = (age > 32'(cfg.hold_time));
   end

   // Stage 3: finish the smoothed level and update the held peak.
   always_comb begin
      s_wide    = $signed({{2{p3_x_ff[15]}}, p3_x_ff}) + p3_step_ff;
      s_new     = s_wide[15:0];
      take      = (s_new >= p3_peak_ff) || p3_exp_ff;
      peak_new  = cfg.lvl_floor;
      stamp_new = p3_stamp_ff;
      if (cfg.hold_en) begin
         peak_new  = take ? s_new : p3_peak_ff;
         stamp_new = take ? p3_now_ff : p3_stamp_ff;
      end
      out_smooth_in = p3_inr_ff ? s_new : cfg.lvl_floor;
      out_peak_in   = p3_inr_ff ? peak_new : cfg.lvl_floor;
   end

   assign wr_en           = mv3 && p3_inr_ff;
   assign wr_addr         = p3_band_ff[AW-1:0];
   assign wr_entry.stamp  = stamp_new;
   assign wr_entry.peak   = peak_new;
   assign wr_entry.smooth = s_new;

   always_comb begin
      p1_vld_in  = accept ? 1'b1 : (mv1 ? 1'b0 : p1_vld_ff);
      p2_vld_in  = mv1 ? 1'b1 : (mv2 ? 1'b0 : p2_vld_ff);
      p3_vld_in  = mv2 ? 1'b1 : (mv3 ? 1'b0 : p3_vld_ff);
      out_vld_in = mv3 ? 1'b1 : (rsp_tready ? 1'b0 : out_vld_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff  <= 1'b0;
         p2_vld_ff  <= 1'b0;
         p3_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         p1_vld_ff  <= p1_vld_in;
         p2_vld_ff  <= p2_vld_in;
         p3_vld_ff  <= p3_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         p1_band_ff <= band_in;
         p1_raw_ff  <= raw_in;
         p1_now_ff  <= now_in;
         p1_inr_ff  <= inr_in;
      end
      if (mv1) begin
         p2_band_ff <= p1_band_ff;
         p2_now_ff  <= p1_now_ff;
         p2_inr_ff  <= p1_inr_ff;
         p2_x_ff    <= p2_x_in;
         p2_ent_ff  <= rd_entry;
      end
      if (mv2) begin
         p3_band_ff  <= p2_band_ff;
         p3_now_ff   <= p2_now_ff;
         p3_inr_ff   <= p2_inr_ff;
         p3_x_ff     <= p2_x_ff;
         p3_step_ff  <= p3_step_in;
         p3_peak_ff  <= p2_ent_ff.peak;
         p3_stamp_ff <= p2_ent_ff.stamp;
         p3_exp_ff   <= p3_exp_in;
      end
      if (mv3) begin
         out_band_ff   <= p3_band_ff;
         out_smooth_ff <= out_smooth_in;
         out_peak_ff   <= out_peak_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {out_peak_ff, out_smooth_ff, out_band_ff};

   // The interlock keeps every in-range band in flight distinct.
   a_distinct_bands: assert property (@(posedge clock) disable iff (reset)
      !((p1_vld_ff && p1_inr_ff && p2_vld_ff && p2_inr_ff && (p1_band_ff == p2_band_ff)) ||
        (p1_vld_ff && p1_inr_ff && p3_vld_ff && p3_inr_ff && (p1_band_ff == p3_band_ff)) ||
        (p2_vld_ff && p2_inr_ff && p3_vld_ff && p3_inr_ff && (p2_band_ff == p3_band_ff))))
      else $error("two items of the same band are in flight");

   a_no_rw_same_entry: assert property (@(posedge clock) disable iff (reset)
      (rd_en && wr_en) |-> (rd_addr != wr_addr))
      else $error("store read and write hit the same entry");

   a_write_then_result: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> rsp_tvalid)
      else $error("store write without a result transfer pending");

   a_hold_off_floor: assert property (@(posedge clock) disable iff (reset)
      (mv3 && !cfg.hold_en) |=> (out_peak_ff == $past(cfg.lvl_floor)))
      else $error("held peak differs from floor with hold disabled");

endmodule

`default_nettype wire

/* design/spectrum_band_smooth_peak_hold_top.sv */
// Top level of the spectrum band smoothing and peak hold block.
//
//   group   direction  tdata fields, lowest bit first
//   req_    in         band_number[7:0], raw_level[23:8], time_ms[55:24]
//   rsp_    out        band_out[7:0], smoothed_level[23:8], held_peak[39:24]
//   csr_    in         csr_we, csr_index (register 0..7), csr_wdata (16 bits)
//
// One band per cycle is accepted unless the band interlock or backpressure stalls it;
// each result is registered in turn by the stages and the output register. A band
// that is still among the three items ahead of it in the pipeline waits until that item has written the store.
// Synchronous reset loads the register defaults; the stores then read as the
// floor through per-band valid bits, so no clearing pass is needed.
// Backpressure on rsp_ fills the output register and the stages one by one.
`default_nettype none

module spectrum_band_smooth_peak_hold_top #(
   parameter int BAND_COUNT = sbsph_pkg::BAND_COUNT_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // band_number, raw_level, time_ms
   input  wire logic [sbsph_pkg::REQ_W-1:0]         req_tdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // band_out, smoothed_level, held_peak
   output logic [sbsph_pkg::RSP_W-1:0]              rsp_tdata,
   input  wire logic                                csr_we,
   input  wire logic [sbsph_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [sbsph_pkg::CSR_W-1:0]         csr_wdata
);

   // Bands are 8 bits wide, so no more entries than that can ever be addressed.
   localparam int MAX_BANDS = 2 ** sbsph_pkg::BAND_W;
   localparam int DEPTH     = (BAND_COUNT < MAX_BANDS) ? BAND_COUNT : MAX_BANDS;
   localparam int AW        = $clog2(DEPTH);

   sbsph_pkg::cfg_type   cfg;
   logic                 store_clear;
   logic                 rd_en, wr_en;
   logic [AW-1:0]        rd_addr, wr_addr;
   sbsph_pkg::entry_type rd_entry, wr_entry;

   sbsph_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cfg         (cfg),
      .store_clear (store_clear)
   );

   sbsph_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock       (clock),
      .reset       (reset),
      .store_clear (store_clear),
      .clear_level (cfg.lvl_floor),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_entry    (rd_entry),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_entry    (wr_entry)
   );

   sbsph_pipe #(
      .BAND_COUNT (BAND_COUNT),
      .AW         (AW)
   ) u_pipe (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_entry   (rd_entry),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_entry   (wr_entry)
   );

endmodule

`default_nettype wire
